// ----- rtl/rpj_pkg.sv -----
// package for the stereo reprojection forward warp
// item payload types, configuration register types, indexes and reset values
// no dependencies
package rpj_pkg;

  typedef struct packed {
    logic [11:0] pixel_col;
    logic [11:0] pixel_row;
    logic [7:0]  disparity_value;
    logic [7:0]  src_red;
    logic [7:0]  src_green;
    logic [7:0]  src_blue;
  } pix_in_t;

  typedef struct packed {
    logic [11:0] target_col;
    logic [11:0] target_row;
    logic [7:0]  dst_red;
    logic [7:0]  dst_green;
    logic [7:0]  dst_blue;
    logic        write_valid;
  } pix_out_t;

  typedef struct packed {
    logic [53:0] rot_x;
    logic [53:0] rot_y;
    logic [53:0] rot_z;
    logic [62:0] trans;
    logic [39:0] focal;
    logic [39:0] pp;
    logic [19:0] base;
  } cfg_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // colour plus no-write flag, carried alongside the arithmetic
  typedef struct packed {
    rgb_t rgb;
    logic nw;
  } side_t;

  typedef struct packed {
    logic signed [36:0] px;
    logic signed [36:0] py;
    logic signed [36:0] pz;
    logic signed [38:0] tx;
    logic signed [38:0] ty;
    logic signed [38:0] tz;
    side_t              side;
  } point_t;

  typedef struct packed {
    logic signed [40:0] p0;
    logic signed [40:0] p1;
    logic signed [40:0] p2;
    side_t              side;
  } proj_t;

  typedef struct packed {
    logic signed [22:0] qx;
    logic signed [22:0] qy;
    logic               ovf;
    side_t              side;
  } div_out_t;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 63;

  localparam logic [CfgIdxW-1:0] CFG_ROT_X = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_ROT_Y = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_ROT_Z = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_TRANS = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_FOCAL = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_PP    = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_BASE  = 3'd6;

  localparam logic [53:0] ROT_X_RST = 54'd65536;
  localparam logic [53:0] ROT_Y_RST = 54'd17179869184;
  localparam logic [53:0] ROT_Z_RST = 54'd4503599627370496;
  localparam logic [62:0] TRANS_RST = 63'd0;
  localparam logic [39:0] FOCAL_RST = 40'd134217856000;
  localparam logic [39:0] PP_RST    = 40'd64424591360;
  localparam logic [19:0] BASE_RST  = 20'd6554;

endpackage

// ----- rtl/rpj_backproj.sv -----
// back-projection: three stages from pixel and disparity to the scaled 3d point
// and the scaled translation terms
// depends on rpj_pkg
module rpj_backproj import rpj_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    en_i,
  input  logic    valid_i,
  input  pix_in_t pix_i,
  input  cfg_t    cfg_i,
  output logic    valid_o,
  output point_t  pt_o
);

  logic [19:0] fx, fy, cx, cy;
  assign fx = cfg_i.focal[19:0];
  assign fy = cfg_i.focal[39:20];
  assign cx = cfg_i.pp[19:0];
  assign cy = cfg_i.pp[39:20];

  // stage 1
  logic               v1_q;
  logic signed [21:0] a1_q, b1_q;
  logic [39:0]        bfy1_q, bfx1_q;
  logic [27:0]        dfy1_q;
  side_t              side1_q;

  // stage 2
  logic               v2_q;
  logic signed [42:0] axl2_q, axh2_q, byl2_q, byh2_q;
  logic [39:0]        zl2_q, zh2_q;
  logic signed [49:0] t02_q, t12_q, t22_q;
  side_t              side2_q;

  // stage 3
  logic               v3_q;
  point_t             pt3_q;

  logic signed [63:0] xf, yf;
  logic [59:0]        zf;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a1_q          <= $signed({2'b00, pix_i.pixel_col, 8'h00}) - $signed({2'b00, cx});
      b1_q          <= $signed({2'b00, pix_i.pixel_row, 8'h00}) - $signed({2'b00, cy});
      bfy1_q        <= cfg_i.base * fy;
      bfx1_q        <= cfg_i.base * fx;
      dfy1_q        <= pix_i.disparity_value * fy;
      side1_q.rgb   <= '{red: pix_i.src_red, green: pix_i.src_green, blue: pix_i.src_blue};
      side1_q.nw    <= (pix_i.disparity_value == 8'd0);

      axl2_q  <= a1_q * $signed({1'b0, bfy1_q[19:0]});
      axh2_q  <= a1_q * $signed({1'b0, bfy1_q[39:20]});
      byl2_q  <= b1_q * $signed({1'b0, bfx1_q[19:0]});
      byh2_q  <= b1_q * $signed({1'b0, bfx1_q[39:20]});
      zl2_q   <= bfx1_q[19:0] * fy;
      zh2_q   <= bfx1_q[39:20] * fy;
      t02_q   <= $signed(cfg_i.trans[20:0]) * $signed({1'b0, dfy1_q});
      t12_q   <= $signed(cfg_i.trans[41:21]) * $signed({1'b0, dfy1_q});
      t22_q   <= $signed(cfg_i.trans[62:42]) * $signed({1'b0, dfy1_q});
      side2_q <= side1_q;

      pt3_q.px   <= xf[60:24];
      pt3_q.py   <= yf[60:24];
      pt3_q.pz   <= $signed({1'b0, zf[59:24]});
      pt3_q.tx   <= t02_q[48:10];
      pt3_q.ty   <= t12_q[48:10];
      pt3_q.tz   <= t22_q[48:10];
      pt3_q.side <= side2_q;
    end
  end

  always_comb begin
    xf = (64'(axh2_q) <<< 20) + 64'(axl2_q);
    yf = (64'(byh2_q) <<< 20) + 64'(byl2_q);
    zf = {zh2_q, 20'h00000} + 60'(zl2_q);
  end

  assign valid_o = v3_q;
  assign pt_o    = pt3_q;

endmodule

// ----- rtl/rpj_rotate.sv -----
// rigid transform: three stages of rotation products, partial sums and the
// final sum with translation, giving the camera-frame point
// depends on rpj_pkg
module rpj_rotate import rpj_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   en_i,
  input  logic   valid_i,
  input  point_t pt_i,
  input  cfg_t   cfg_i,
  output logic   valid_o,
  output proj_t  pr_o
);

  logic signed [17:0] rot [3][3];
  logic signed [36:0] pc  [3];
  logic signed [38:0] tin [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rot[0][k] = cfg_i.rot_x[18*k +: 18];
      rot[1][k] = cfg_i.rot_y[18*k +: 18];
      rot[2][k] = cfg_i.rot_z[18*k +: 18];
    end
    pc[0]  = pt_i.px;
    pc[1]  = pt_i.py;
    pc[2]  = pt_i.pz;
    tin[0] = pt_i.tx;
    tin[1] = pt_i.ty;
    tin[2] = pt_i.tz;
  end

  logic               v4_q, v5_q, v6_q;
  logic signed [37:0] plo4_q [3][3];
  logic signed [35:0] phi4_q [3][3];
  logic signed [38:0] t4_q [3];
  logic signed [38:0] t5_q [3];
  logic signed [55:0] term5_q [3][3];
  side_t              side4_q, side5_q;
  proj_t              pr6_q;

  logic signed [57:0] acc [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else if (en_i) begin
      v4_q <= valid_i;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          plo4_q[i][k]  <= rot[i][k] * $signed({1'b0, pc[k][18:0]});
          phi4_q[i][k]  <= rot[i][k] * $signed(pc[k][36:19]);
          term5_q[i][k] <= (56'(phi4_q[i][k]) <<< 19) + 56'(plo4_q[i][k]);
        end
        t4_q[i] <= tin[i];
        t5_q[i] <= t4_q[i];
      end
      side4_q    <= pt_i.side;
      side5_q    <= side4_q;
      pr6_q.p0   <= acc[0][56:16];
      pr6_q.p1   <= acc[1][56:16];
      pr6_q.p2   <= acc[2][56:16];
      pr6_q.side <= side5_q;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i] = 58'(term5_q[i][0]) + 58'(term5_q[i][1]) + 58'(term5_q[i][2])
             + (58'(t5_q[i]) <<< 16);
    end
  end

  assign valid_o = v6_q;
  assign pr_o    = pr6_q;

endmodule

// ----- rtl/rpj_div.sv -----
// pipelined restoring divider, two lanes over a shared divisor, one quotient
// bit per stage; quotients truncate toward zero, overflow flags |q| >= 2^22
// depends on rpj_pkg
module rpj_div import rpj_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic signed [61:0] num_x_i,
  input  logic signed [61:0] num_y_i,
  input  logic signed [40:0] den_i,
  input  side_t              side_i,
  output logic               valid_o,
  output div_out_t           res_o
);

  localparam int unsigned QW = 22;

  logic [61:0] nneg [2];
  logic [60:0] nabs [2];
  logic [41:0] dneg;
  logic [40:0] dabs;
  logic        ovf_in;

  always_comb begin
    nneg[0] = 62'(0) - num_x_i;
    nneg[1] = 62'(0) - num_y_i;
    nabs[0] = num_x_i[61] ? nneg[0][60:0] : num_x_i[60:0];
    nabs[1] = num_y_i[61] ? nneg[1][60:0] : num_y_i[60:0];
    dneg    = 42'(0) - 42'(den_i);
    dabs    = den_i[40] ? dneg[40:0] : den_i[40:0];
    ovf_in  = ({2'b00, nabs[0][60:QW]} >= dabs) || ({2'b00, nabs[1][60:QW]} >= dabs);
  end

  logic          vld_q  [QW+1];
  logic [40:0]   rem_q  [2][QW+1];
  logic [QW-1:0] nlo_q  [2][QW+1];
  logic [QW-1:0] quo_q  [2][QW+1];
  logic          sgn_q  [2][QW+1];
  logic [40:0]   den_q  [QW+1];
  logic          ovf_q  [QW+1];
  side_t         side_q [QW+1];

  logic [41:0]   rs_c [2][QW];
  logic [41:0]   rn_c [2][QW];
  logic          ge_c [2][QW];

  logic          vout_q;
  div_out_t      res_q;
  logic [22:0]   qneg [2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      for (int s = 0; s < QW; s++) begin
        rs_c[l][s] = {rem_q[l][s], nlo_q[l][s][QW-1]};
        ge_c[l][s] = rs_c[l][s] >= {1'b0, den_q[s]};
        rn_c[l][s] = ge_c[l][s] ? (rs_c[l][s] - {1'b0, den_q[s]}) : rs_c[l][s];
      end
      qneg[l] = 23'(0) - {1'b0, quo_q[l][QW]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s <= QW; s++) begin
        vld_q[s] <= 1'b0;
      end
      vout_q <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
      for (int s = 0; s < QW; s++) begin
        vld_q[s+1] <= vld_q[s];
      end
      vout_q <= vld_q[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0][0] <= {2'b00, nabs[0][60:QW]};
      rem_q[1][0] <= {2'b00, nabs[1][60:QW]};
      nlo_q[0][0] <= nabs[0][QW-1:0];
      nlo_q[1][0] <= nabs[1][QW-1:0];
      quo_q[0][0] <= '0;
      quo_q[1][0] <= '0;
      sgn_q[0][0] <= num_x_i[61] ^ den_i[40];
      sgn_q[1][0] <= num_y_i[61] ^ den_i[40];
      den_q[0]    <= dabs;
      ovf_q[0]    <= ovf_in;
      side_q[0]   <= side_i;
      for (int s = 0; s < QW; s++) begin
        for (int l = 0; l < 2; l++) begin
          rem_q[l][s+1] <= rn_c[l][s][40:0];
          nlo_q[l][s+1] <= {nlo_q[l][s][QW-2:0], 1'b0};
          quo_q[l][s+1] <= {quo_q[l][s][QW-2:0], ge_c[l][s]};
          sgn_q[l][s+1] <= sgn_q[l][s];
        end
        den_q[s+1]  <= den_q[s];
        ovf_q[s+1]  <= ovf_q[s];
        side_q[s+1] <= side_q[s];
      end
      res_q.qx   <= sgn_q[0][QW] ? $signed(qneg[0]) : $signed({1'b0, quo_q[0][QW]});
      res_q.qy   <= sgn_q[1][QW] ? $signed(qneg[1]) : $signed({1'b0, quo_q[1][QW]});
      res_q.ovf  <= ovf_q[QW];
      res_q.side <= side_q[QW];
    end
  end

  assign valid_o = vout_q;
  assign res_o   = res_q;

endmodule

// ----- rtl/stereo_reprojection_forward_warp.sv -----
// top level of the stereo reprojection forward warp: configuration registers,
// projection products, bounds test and output register
// depends on rpj_pkg, rpj_backproj, rpj_rotate, rpj_div
//
//   channel  | handshake                | payload
//   ---------+--------------------------+---------------------------------
//   in       | in_valid_i / in_stall_o  | in_item_i   (pix_in_t)
//   out      | out_valid_o / out_stall_i| out_item_o  (pix_out_t)
//   config   | cfg_we_i                 | cfg_index_i, cfg_wdata_i
//
// one item per cycle while the pipeline is not held under out_stall_i
// most of the pipeline depth lies in the 22 quotient stages of the divider
// reset clears valid bits and loads the configuration reset values
// the whole pipeline holds while a result waits under out_stall_i
module stereo_reprojection_forward_warp import rpj_pkg::*; #(
  parameter int IMAGE_WIDTH  = 640,
  parameter int IMAGE_HEIGHT = 480
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  pix_in_t             in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output pix_out_t            out_item_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  localparam int XLIM = IMAGE_WIDTH * 256;
  localparam int YLIM = IMAGE_HEIGHT * 256;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rot_x <= ROT_X_RST;
      cfg_q.rot_y <= ROT_Y_RST;
      cfg_q.rot_z <= ROT_Z_RST;
      cfg_q.trans <= TRANS_RST;
      cfg_q.focal <= FOCAL_RST;
      cfg_q.pp    <= PP_RST;
      cfg_q.base  <= BASE_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_ROT_X: cfg_q.rot_x <= cfg_wdata_i[53:0];
        CFG_ROT_Y: cfg_q.rot_y <= cfg_wdata_i[53:0];
        CFG_ROT_Z: cfg_q.rot_z <= cfg_wdata_i[53:0];
        CFG_TRANS: cfg_q.trans <= cfg_wdata_i[62:0];
        CFG_FOCAL: cfg_q.focal <= cfg_wdata_i[39:0];
        CFG_PP:    cfg_q.pp    <= cfg_wdata_i[39:0];
        CFG_BASE:  cfg_q.base  <= cfg_wdata_i[19:0];
        default: ;
      endcase
    end
  end

  logic     en;
  logic     out_valid_q;
  pix_out_t out_q;

  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  logic   bp_valid;
  point_t bp_pt;
  logic   rt_valid;
  proj_t  rt_pr;

  rpj_backproj u_backproj (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .pix_i   (in_item_i),
    .cfg_i   (cfg_q),
    .valid_o (bp_valid),
    .pt_o    (bp_pt)
  );

  rpj_rotate u_rotate (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (bp_valid),
    .pt_i    (bp_pt),
    .cfg_i   (cfg_q),
    .valid_o (rt_valid),
    .pr_o    (rt_pr)
  );

  logic [19:0] fx, fy, cx, cy;
  assign fx = cfg_q.focal[19:0];
  assign fy = cfg_q.focal[39:20];
  assign cx = cfg_q.pp[19:0];
  assign cy = cfg_q.pp[39:20];

  // stage 7: projection products split in two halves
  logic               v7_q;
  logic signed [42:0] m0l7_q, m1l7_q;
  logic signed [40:0] m0h7_q, m1h7_q;
  logic signed [40:0] d7_q;
  side_t              side7_q;

  // stage 8: full numerators
  logic               v8_q;
  logic signed [61:0] n08_q, n18_q;
  logic signed [40:0] d8_q;
  side_t              side8_q;

  logic signed [63:0] n0_c, n1_c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v7_q <= 1'b0;
      v8_q <= 1'b0;
    end else if (en) begin
      v7_q <= rt_valid;
      v8_q <= v7_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m0l7_q     <= $signed({1'b0, fx}) * $signed({1'b0, rt_pr.p0[20:0]});
      m0h7_q     <= $signed({1'b0, fx}) * $signed(rt_pr.p0[40:21]);
      m1l7_q     <= $signed({1'b0, fy}) * $signed({1'b0, rt_pr.p1[20:0]});
      m1h7_q     <= $signed({1'b0, fy}) * $signed(rt_pr.p1[40:21]);
      d7_q       <= rt_pr.p2;
      side7_q.rgb <= rt_pr.side.rgb;
      side7_q.nw  <= rt_pr.side.nw || (rt_pr.p2 == 41'sd0);

      n08_q   <= n0_c[61:0];
      n18_q   <= n1_c[61:0];
      d8_q    <= d7_q;
      side8_q <= side7_q;
    end
  end

  always_comb begin
    n0_c = (64'(m0h7_q) <<< 21) + 64'(m0l7_q);
    n1_c = (64'(m1h7_q) <<< 21) + 64'(m1l7_q);
  end

  logic     dv_valid;
  div_out_t dv_res;

  rpj_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v8_q),
    .num_x_i (n08_q),
    .num_y_i (n18_q),
    .den_i   (d8_q),
    .side_i  (side8_q),
    .valid_o (dv_valid),
    .res_o   (dv_res)
  );

  logic signed [24:0] xp, yp;
  logic               wr;
  pix_out_t           out_d;

  always_comb begin
    xp = 25'(dv_res.qx) + $signed({5'b00000, cx});
    yp = 25'(dv_res.qy) + $signed({5'b00000, cy});
    wr = !dv_res.side.nw && !dv_res.ovf
      && (xp > 25'sd0) && (xp < 25'(XLIM))
      && (yp > 25'sd0) && (yp < 25'(YLIM));
    out_d = '0;
    if (wr) begin
      out_d.target_col  = xp[19:8];
      out_d.target_row  = yp[19:8];
      out_d.dst_red     = dv_res.side.rgb.red;
      out_d.dst_green   = dv_res.side.rgb.green;
      out_d.dst_blue    = dv_res.side.rgb.blue;
      out_d.write_valid = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_col_in_image: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.write_valid
      |-> {1'b0, out_item_o.target_col} < 13'(IMAGE_WIDTH))
    else $error("write column outside image");

  a_row_in_image: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.write_valid
      |-> {1'b0, out_item_o.target_row} < 13'(IMAGE_HEIGHT))
    else $error("write row outside image");

  a_nowrite_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.write_valid
      |-> out_item_o.target_col == 12'd0 && out_item_o.target_row == 12'd0
       && out_item_o.dst_red == 8'd0 && out_item_o.dst_green == 8'd0
       && out_item_o.dst_blue == 8'd0)
    else $error("fields not cleared on a non-write item");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a held result");

endmodule

// ----- tb/stereo_reprojection_forward_warp_tb.sv -----
// testbench for the stereo reprojection forward warp: directed table, config corners, then
// random pixels under random idling on both sides, each checked against a fixed-point predictor
// depends on rpj_pkg and stereo_reprojection_forward_warp
module stereo_reprojection_forward_warp_tb;
  import rpj_pkg::*;

  localparam int ImgW = 640;
  localparam int ImgH = 480;
  localparam int Latency = 33;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  pix_in_t in_item_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  pix_out_t out_item_o;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;

  stereo_reprojection_forward_warp uut (.*);

  always #5 clk_i = ~clk_i;

  logic [53:0] rot_rows [3];
  logic [62:0] trans_reg;
  logic [39:0] focal_reg;
  logic [39:0] pp_reg;
  logic [19:0] base_reg;

  pix_out_t warp_queue [$];
  int n_bad = 0;
  bit calm = 1'b0;
  bit hold_out = 1'b0;

  function automatic longint floor_div(longint v, int n);
    return v >>> n;
  endfunction

  function automatic pix_out_t warp_pixel(pix_in_t p);
    pix_out_t r;
    longint u, v, d, fx, fy, cx, cy, b, x, y, t, ts, acc;
    longint pt [3];
    longint pr [3];
    r = '0;
    u = longint'(p.pixel_col);
    v = longint'(p.pixel_row);
    d = longint'(p.disparity_value);
    fx = longint'(focal_reg[19:0]);
    fy = longint'(focal_reg[39:20]);
    cx = longint'(pp_reg[19:0]);
    cy = longint'(pp_reg[39:20]);
    b = longint'(base_reg);
    if (d == 0) return r;
    pt[0] = floor_div((u * 256 - cx) * b * fy, 24);
    pt[1] = floor_div((v * 256 - cy) * b * fx, 24);
    pt[2] = floor_div(b * fx * fy, 24);
    for (int i = 0; i < 3; i++) begin
      t = longint'($signed(trans_reg[21*i +: 21]));
      ts = floor_div(t * d * fy, 10);
      acc = ts * 65536;
      for (int k = 0; k < 3; k++) begin
        acc += longint'($signed(rot_rows[i][18*k +: 18])) * pt[k];
      end
      pr[i] = floor_div(acc, 16);
    end
    if (pr[2] == 0) return r;
    x = (fx * pr[0]) / pr[2] + cx;
    y = (fy * pr[1]) / pr[2] + cy;
    if (x > 0 && x < ImgW * 256 && y > 0 && y < ImgH * 256) begin
      r.target_col = x[19:8];
      r.target_row = y[19:8];
      r.dst_red = p.src_red;
      r.dst_green = p.src_green;
      r.dst_blue = p.src_blue;
      r.write_valid = 1'b1;
    end
    return r;
  endfunction

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_ROT_X: rot_rows[0] = val[53:0];
      CFG_ROT_Y: rot_rows[1] = val[53:0];
      CFG_ROT_Z: rot_rows[2] = val[53:0];
      CFG_TRANS: trans_reg = val[62:0];
      CFG_FOCAL: focal_reg = val[39:0];
      CFG_PP: pp_reg = val[39:0];
      CFG_BASE: base_reg = val[19:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic drain();
    while (warp_queue.size() != 0) @(negedge clk_i);
    repeat (Latency + 5) @(negedge clk_i);
  endtask

  // one item, with a random gap first if gap is set and not calm
  task automatic send_pixel(pix_in_t p, bit gap);
    if (gap && !calm && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= p;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    warp_queue.push_back(warp_pixel(p));
    @(negedge clk_i);
  endtask

  task automatic idle_input();
    in_valid_i <= 1'b0;
  endtask

  function automatic pix_in_t rand_pixel(bit near);
    pix_in_t p;
    p = pix_in_t'(56'({$urandom, $urandom}));
    if (near) begin
      p.pixel_col = 12'($urandom_range(0, 700));
      p.pixel_row = 12'($urandom_range(0, 520));
      if ($urandom_range(0, 9) != 0 && p.disparity_value == 8'd0) p.disparity_value = 8'd1;
    end
    return p;
  endfunction

  function automatic logic [53:0] near_identity(int row);
    logic [53:0] r;
    for (int k = 0; k < 3; k++) begin
      r[18*k +: 18] = (k == row) ? 18'd65536 - 18'($urandom_range(0, 300))
                                 : 18'($signed($urandom_range(0, 1200)) - 600);
    end
    return r;
  endfunction

  // directed stimulus table: pixel, expected result where it is obvious, check flag
  typedef struct {
    pix_in_t px;
    pix_out_t want;
    bit typed;
  } row_t;

  row_t dir_rows [$];

  always @(posedge clk_i) begin
    pix_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (warp_queue.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("unexpected item %p", out_item_o);
      end else begin
        want = warp_queue.pop_front();
        if (want !== out_item_o) begin
          n_bad++;
          if (n_bad <= 10) $display("mismatch: expected %p, got %p", want, out_item_o);
        end
      end
    end
  end

  // receiver stall bursts and one long hold-off
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_out) begin
        out_stall_i <= 1'b1;
        repeat (120) @(negedge clk_i);
        out_stall_i <= 1'b0;
        hold_out = 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 13)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    pix_in_t p;
    row_t r;
    rot_rows[0] = ROT_X_RST;
    rot_rows[1] = ROT_Y_RST;
    rot_rows[2] = ROT_Z_RST;
    trans_reg = TRANS_RST;
    focal_reg = FOCAL_RST;
    pp_reg = PP_RST;
    base_reg = BASE_RST;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // zero disparity, extremes, centre pixel, off-image pixels
    r.typed = 1'b1;
    r.want = '0;
    r.px = '{12'd100, 12'd100, 8'd0, 8'hff, 8'hff, 8'hff};
    dir_rows.push_back(r);
    r.px = '{12'd4095, 12'd4095, 8'd0, 8'h00, 8'h00, 8'h00};
    dir_rows.push_back(r);
    r.typed = 1'b0;
    r.px = '{12'd320, 12'd240, 8'd1, 8'hff, 8'h00, 8'haa};
    dir_rows.push_back(r);
    r.px = '{12'd0, 12'd0, 8'd255, 8'h12, 8'h34, 8'h56};
    dir_rows.push_back(r);
    r.px = '{12'd4095, 12'd4095, 8'd255, 8'hff, 8'hff, 8'hff};
    dir_rows.push_back(r);
    r.px = '{12'd639, 12'd479, 8'd128, 8'h55, 8'haa, 8'h01};
    dir_rows.push_back(r);
    r.px = '{12'd1, 12'd1, 8'd7, 8'h80, 8'h40, 8'h20};
    dir_rows.push_back(r);
    r.px = '{12'd640, 12'd480, 8'd9, 8'h01, 8'h02, 8'h03};
    dir_rows.push_back(r);
    foreach (dir_rows[i]) begin
      send_pixel(dir_rows[i].px, 1'b0);
      if (dir_rows[i].typed && warp_queue[$] !== dir_rows[i].want) begin
        n_bad++;
        if (n_bad <= 10) $display("table row %0d: predictor disagrees with the typed result", i);
      end
    end
    idle_input();
    drain();

    // zero focal length y: zero depth, then a translation that places points behind
    write_reg(CFG_FOCAL, CfgDataW'({20'd0, 20'd128000}));
    send_pixel('{12'd320, 12'd240, 8'd5, 8'h11, 8'h22, 8'h33}, 1'b0);
    idle_input();
    drain();
    write_reg(CFG_FOCAL, CfgDataW'(FOCAL_RST));
    write_reg(CFG_TRANS, {21'h100000, 21'h0ffc00, 21'h1ffc00});
    for (int i = 0; i < 4; i++) send_pixel(rand_pixel(1'b1), 1'b0);
    idle_input();
    drain();
    // register extremes
    write_reg(CFG_ROT_X, CfgDataW'({54{1'b1}}));
    write_reg(CFG_ROT_Y, CfgDataW'(54'h0));
    write_reg(CFG_ROT_Z, CfgDataW'({1'b0, {53{1'b1}}}));
    write_reg(CFG_TRANS, {63{1'b1}});
    write_reg(CFG_FOCAL, CfgDataW'({40{1'b1}}));
    write_reg(CFG_PP, CfgDataW'({40{1'b1}}));
    write_reg(CFG_BASE, CfgDataW'(20'hfffff));
    for (int i = 0; i < 6; i++) send_pixel(rand_pixel(1'b0), 1'b0);
    idle_input();
    drain();
    write_reg(CFG_ROT_X, CfgDataW'(54'h0));
    write_reg(CFG_PP, CfgDataW'(40'h0));
    write_reg(CFG_BASE, CfgDataW'(20'h0));
    for (int i = 0; i < 3; i++) send_pixel(rand_pixel(1'b0), 1'b0);
    idle_input();
    drain();

    // random phases with varied, mostly plausible geometry
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_ROT_X, CfgDataW'(near_identity(0)));
      write_reg(CFG_ROT_Y, CfgDataW'(near_identity(1)));
      write_reg(CFG_ROT_Z, CfgDataW'(near_identity(2)));
      write_reg(CFG_TRANS, {21'($signed($urandom_range(0, 400)) - 200),
                            21'($signed($urandom_range(0, 400)) - 200),
                            21'($signed($urandom_range(0, 400)) - 200)});
      write_reg(CFG_FOCAL, CfgDataW'({20'($urandom_range(64000, 256000)),
                                      20'($urandom_range(64000, 256000))}));
      write_reg(CFG_PP, CfgDataW'({20'($urandom_range(40000, 80000)),
                                   20'($urandom_range(60000, 100000))}));
      write_reg(CFG_BASE, CfgDataW'(20'($urandom_range(1000, 60000))));
      if (ph == 5) calm = 1'b1;
      for (int i = 0; i < 90; i++) begin
        if (ph == 2 && i == 10) hold_out = 1'b1;
        if (ph == 3 && i == 45) begin
          idle_input();
          while (warp_queue.size() != 0) @(negedge clk_i);
        end
        send_pixel(rand_pixel($urandom_range(0, 9) != 0), 1'b1);
      end
      idle_input();
      drain();
    end

    if (n_bad == 0 && warp_queue.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/rpj_pkg.sv
rtl/rpj_backproj.sv
rtl/rpj_rotate.sv
rtl/rpj_div.sv
rtl/stereo_reprojection_forward_warp.sv
tb/stereo_reprojection_forward_warp_tb.sv
